// ===== rtl/core/complex_float_multiply_top_macros.svh =====
// assertion macros shared by the complex multiply rtl
// no dependencies
`ifndef COMPLEX_FLOAT_MULTIPLY_TOP_MACROS_SVH
`define COMPLEX_FLOAT_MULTIPLY_TOP_MACROS_SVH
// implication checked on every clock, quiet during reset
`define CFM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// same check, also active during reset
`define CFM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== rtl/core/cfm_pkg.sv =====
// package for the complex single-precision multiply: constants, types, float functions
// no dependencies
`timescale 1ns / 1ps
package cfm_pkg;
   localparam int unsigned FloatWidth  = 32;
   localparam int unsigned PipeDepth   = 4;
   localparam logic [31:0] QnanBits = 32'h7FC0_0000;
   localparam logic [31:0] InfBits  = 32'h7F80_0000;

   // unpacked product: sig is 48 bit raw significand product, exp is scale of lsb
   typedef struct packed {
      logic        special;
      logic [31:0] special_bits;
      logic        sign;
      logic signed [10:0] exp;
      logic [47:0] sig;
   } mul_raw_type;

   function automatic logic is_nan(input logic [31:0] x);
      return x[30:0] > InfBits[30:0];
   endfunction

   function automatic logic is_inf(input logic [31:0] x);
      return x[30:0] == InfBits[30:0];
   endfunction

   function automatic logic is_zero(input logic [31:0] x);
      return x[30:0] == 31'd0;
   endfunction

   function automatic logic [23:0] sig_of(input logic [31:0] x);
      return {(x[30:23] != 8'd0), x[22:0]};
   endfunction

   function automatic logic signed [10:0] exp_of(input logic [31:0] x);
      return (x[30:23] != 8'd0) ? {3'b000, x[30:23]} : 11'sd1;
   endfunction

   // leading one position of a 64 bit word
   function automatic logic [5:0] lead_pos(input logic [63:0] v);
      logic [5:0] p;
      p = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) begin
            p = 6'(i);
         end
      end
      return p;
   endfunction

   // round sig * 2^e to single, ties to even
   function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
                                              input logic [63:0] sig);
      logic [5:0]  k;
      logic signed [12:0] be;
      logic signed [12:0] sh;
      logic [63:0] m;
      logic [63:0] rem;
      logic [63:0] half;
      logic [63:0] mask;
      logic [8:0]  ef;
      logic [32:0] bits;
      k  = lead_pos(sig);
      be = 13'(signed'({1'b0, k})) + 13'(e) + 13'sd127;
      sh = (be >= 13'sd1) ? (13'(signed'({1'b0, k})) - 13'sd23) : -(13'(e) + 13'sd149);
      m  = 64'd0;
      if (sh <= 13'sd0) begin
         m = sig << 6'(-sh);
      end else if (sh > 13'sd64) begin
         m = 64'd0;
      end else begin
         if (sh < 13'sd64) begin
            mask = (64'd1 << 6'(sh)) - 64'd1;
            m    = sig >> 6'(sh);
            rem  = sig & mask;
         end else begin
            m   = 64'd0;
            rem = sig;
         end
         half = 64'd1 << 6'(sh - 13'sd1);
         if ((rem > half) || ((rem == half) && m[0])) begin
            m = m + 64'd1;
         end
      end
      ef   = (be >= 13'sd1) ? 9'(be - 13'sd1) : 9'd0;
      bits = {ef, 23'd0} + 33'(m[24:0]);
      if (bits >= {1'b0, InfBits}) begin
         bits = {1'b0, InfBits};
      end
      return {s, bits[30:0]};
   endfunction
endpackage

// ===== rtl/core/cfm_stream_if.sv =====
// valid/ready channel interface carrying a parameterised payload
// depends on nothing
`timescale 1ns / 1ps
interface cfm_stream_if #(parameter int unsigned Width = 1);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/cfm_mul_stage.sv =====
// one single-precision multiply split over two register stages
// depends on cfm_pkg
`timescale 1ns / 1ps
module cfm_mul_stage (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] x,
   input  logic [31:0] y,
   output logic [31:0] p
);
   cfm_pkg::mul_raw_type raw_ff, raw_in;
   logic [31:0] p_ff, p_in;

   always_comb begin
      raw_in              = '0;
      raw_in.sign         = x[31] ^ y[31];
      raw_in.exp          = cfm_pkg::exp_of(x) + cfm_pkg::exp_of(y) - 11'sd300;
      raw_in.sig          = 48'(cfm_pkg::sig_of(x)) * 48'(cfm_pkg::sig_of(y));
      if (cfm_pkg::is_nan(x) || cfm_pkg::is_nan(y)) begin
         raw_in.special      = 1'b1;
         raw_in.special_bits = cfm_pkg::QnanBits;
      end else if (cfm_pkg::is_inf(x) || cfm_pkg::is_inf(y)) begin
         raw_in.special      = 1'b1;
         raw_in.special_bits = (cfm_pkg::is_zero(x) || cfm_pkg::is_zero(y)) ?
                               cfm_pkg::QnanBits : {raw_in.sign, cfm_pkg::InfBits[30:0]};
      end else if (cfm_pkg::is_zero(x) || cfm_pkg::is_zero(y)) begin
         raw_in.special      = 1'b1;
         raw_in.special_bits = {raw_in.sign, 31'd0};
      end
   end

   assign p_in = raw_ff.special ? raw_ff.special_bits :
                 cfm_pkg::round_pack(raw_ff.sign, 12'(raw_ff.exp), {16'd0, raw_ff.sig});

   always_ff @(posedge clock) begin
      if (en) begin
         raw_ff <= raw_in;
         p_ff   <= p_in;
      end
   end

   assign p = p_ff;
endmodule

// ===== rtl/core/cfm_add_stage.sv =====
// single-precision add split over two register stages: align then round
// depends on cfm_pkg
`timescale 1ns / 1ps
module cfm_add_stage (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] x,
   input  logic [31:0] y,
   output logic [31:0] s
);
   localparam int unsigned AlignExtra = 38;

   logic        spec_ff, spec_in;
   logic [31:0] sbits_ff, sbits_in;
   logic        sign_ff, sign_in;
   logic signed [11:0] exp_ff, exp_in;
   logic [63:0] sig_ff, sig_in;
   logic [31:0] s_ff, s_in;

   always_comb begin
      logic        sx, sy, ts;
      logic signed [10:0] ex, ey, te, d;
      logic [63:0] mx, my, tm, lost;
      ts   = 1'b0;
      te   = '0;
      tm   = '0;
      lost = '0;
      sx = x[31];
      sy = y[31];
      ex = cfm_pkg::exp_of(x);
      ey = cfm_pkg::exp_of(y);
      mx = 64'(cfm_pkg::sig_of(x)) << AlignExtra;
      my = 64'(cfm_pkg::sig_of(y)) << AlignExtra;
      if ((ey > ex) || ((ey == ex) && (my > mx))) begin
         ts = sx; sx = sy; sy = ts;
         te = ex; ex = ey; ey = te;
         tm = mx; mx = my; my = tm;
      end
      d = ex - ey;
      if (d >= 11'sd62) begin
         my = 64'd1;
      end else if (d > 11'sd0) begin
         lost = my & ((64'd1 << 6'(d)) - 64'd1);
         my   = (my >> 6'(d)) | 64'(lost != 64'd0);
      end
      sig_in   = (sx == sy) ? (mx + my) : (mx - my);
      sign_in  = sx;
      exp_in   = 12'(ex) - 12'sd188;
      spec_in  = 1'b1;
      sbits_in = 32'd0;
      if (cfm_pkg::is_nan(x) || cfm_pkg::is_nan(y)) begin
         sbits_in = cfm_pkg::QnanBits;
      end else if (cfm_pkg::is_inf(x)) begin
         sbits_in = (cfm_pkg::is_inf(y) && (x[31] != y[31])) ? cfm_pkg::QnanBits : x;
      end else if (cfm_pkg::is_inf(y)) begin
         sbits_in = y;
      end else if (cfm_pkg::is_zero(x) && cfm_pkg::is_zero(y)) begin
         sbits_in = {x[31] & y[31], 31'd0};
      end else if (cfm_pkg::is_zero(x)) begin
         sbits_in = y;
      end else if (cfm_pkg::is_zero(y)) begin
         sbits_in = x;
      end else if (sig_in == 64'd0) begin
         sbits_in = 32'd0; // exact cancellation gives +0
      end else begin
         spec_in = 1'b0;
      end
   end

   assign s_in = spec_ff ? sbits_ff : cfm_pkg::round_pack(sign_ff, exp_ff, sig_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         spec_ff  <= spec_in;
         sbits_ff <= sbits_in;
         sign_ff  <= sign_in;
         exp_ff   <= exp_in;
         sig_ff   <= sig_in;
         s_ff     <= s_in;
      end
   end

   assign s = s_ff;
endmodule

// ===== rtl/core/complex_float_multiply_top.sv =====
// complex single-precision multiply, top level: handshake, pipeline control, datapath
// depends on cfm_pkg, cfm_stream_if, cfm_mul_stage, cfm_add_stage and the macros header
`timescale 1ns / 1ps
`include "complex_float_multiply_top_macros.svh"
// Complex single-precision multiply. One request carries a = a_real + j*a_imag,
// b = b_real + j*b_imag and a last flag; one response carries the product a*b
// (or a*conj(b) when csr conj_mode is set) and the same flag. Products and the
// final sum are each rounded to nearest-even, subnormals, infinities and NaNs
// follow IEEE 754 and every NaN comes out as 0x7FC00000. A new request is taken
// every cycle while the pipe is not frozen; there are five register stages between
// an accepted request and its response: two stages of multiply (raw product,
// round), two of add (align, round) and an output register. The whole pipe
// advances together and freezes only when the output register holds a response
// that is not taken, so a stall loses nothing.
// conj_mode is sampled as a request enters and should only change while idle.
module complex_float_multiply_top (
   input  logic clock,
   input  logic reset,
   cfm_stream_if.sink   req,
   cfm_stream_if.source rsp,
   input  logic csr_we,
   input  logic csr_wdata
);
   localparam int unsigned Depth = cfm_pkg::PipeDepth; // valid stages before output

   logic conj_ff;
   logic [Depth-1:0] vld_ff;
   logic [Depth-1:0] last_ff;
   logic [Depth-2:0] conj_pipe_ff;
   logic out_vld_ff;
   logic [64:0] out_data_ff;
   logic adv;

   // request fields
   logic [31:0] a_real, a_imag, b_real, b_imag;
   logic        last_element;
   assign {a_real, a_imag, b_real, b_imag, last_element} = req.data;

   // pipe moves unless output holds an untaken response
   assign adv       = !out_vld_ff || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         conj_ff <= 1'b0;
      end else if (csr_we) begin
         conj_ff <= csr_wdata;
      end
   end

   // partial products
   logic [31:0] rr, ii, ri, ir;
   cfm_mul_stage u_rr (.clock(clock), .en(adv), .x(a_real), .y(b_real), .p(rr));
   cfm_mul_stage u_ii (.clock(clock), .en(adv), .x(a_imag), .y(b_imag), .p(ii));
   cfm_mul_stage u_ri (.clock(clock), .en(adv), .x(a_real), .y(b_imag), .p(ri));
   cfm_mul_stage u_ir (.clock(clock), .en(adv), .x(a_imag), .y(b_real), .p(ir));

   // conj selects signs at the adder inputs
   logic        cj;
   logic [31:0] re_x, re_y, im_x, im_y, re_s, im_s;
   assign cj   = conj_pipe_ff[Depth-3];
   assign re_x = rr;
   assign re_y = cj ? ii : {~ii[31], ii[30:0]};
   assign im_x = cj ? ir : ri;
   assign im_y = cj ? {~ri[31], ri[30:0]} : ir;

   cfm_add_stage u_re (.clock(clock), .en(adv), .x(re_x), .y(re_y), .s(re_s));
   cfm_add_stage u_im (.clock(clock), .en(adv), .x(im_x), .y(im_y), .s(im_s));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[Depth-2:0], req.valid};
         out_vld_ff <= vld_ff[Depth-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         last_ff      <= {last_ff[Depth-2:0], last_element};
         conj_pipe_ff <= {conj_pipe_ff[Depth-3:0], conj_ff};
         out_data_ff  <= {re_s, im_s, last_ff[Depth-1]};
      end
   end

   assign rsp.valid = out_vld_ff;
   assign rsp.data  = out_data_ff;

   `CFM_ASSERT(a_hold, clock, reset, (rsp.valid && !rsp.ready) |=> $stable(rsp.data), "response changed while stalled")
   `CFM_ASSERT(a_flow, clock, reset, (req.valid && req.ready) |=> vld_ff[0], "accepted request not tracked")
   `CFM_ASSERT_ALWAYS(a_rst, clock, $past(reset) |-> !rsp.valid, "response valid after reset")
endmodule
